@@ sv/mm_pkg.sv @@
// Package for the matrix multiply block: sizes, types, register indexes,
// controller states and the command/status structs, used by every module but mm_ram.
// No dependencies.
`default_nettype none

package mm_pkg;

  // Sizes
  localparam int MAX_DIM    = 8;
  localparam int ELEM_WIDTH = 16;
  localparam int PROD_WIDTH = 35;
  localparam int DIM_W      = 4;
  localparam int IDX_W      = $clog2(MAX_DIM);
  localparam int DEPTH      = MAX_DIM * MAX_DIM;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = 7;
  localparam int TOT_W      = $clog2(2 * DEPTH + 1);
  localparam int REG_IDX_W  = 2;

  typedef logic [DIM_W-1:0]              dim_t;
  typedef logic [IDX_W-1:0]              idx_t;
  typedef logic [ADDR_W-1:0]             addr_t;
  typedef logic [CNT_W-1:0]              cnt_t;
  typedef logic [TOT_W-1:0]              tot_t;
  typedef logic [REG_IDX_W-1:0]          reg_idx_t;
  typedef logic signed [ELEM_WIDTH-1:0]  elem_t;
  typedef logic signed [2*ELEM_WIDTH-1:0] mul_t;
  typedef logic signed [PROD_WIDTH-1:0]  prod_t;

  // Configuration register indexes
  localparam reg_idx_t REG_ROWS_A    = 2'd0;
  localparam reg_idx_t REG_INNER_DIM = 2'd1;
  localparam reg_idx_t REG_COLS_B    = 2'd2;

  // Reset value of every dimension register
  localparam dim_t DIM_RESET = dim_t'(MAX_DIM);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_ISSUE,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;       // element transfer: write store, bump load count
    logic start;      // last element of B: reset walk counters
    logic issue;      // read one A/B pair, step inner index
    logic next_elem;  // move to next product element
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic load_last;  // current element completes the load
    logic issue_last; // inner index at its final value
    logic mac_done;   // final term in accumulate stage, result register loads
    logic elem_last;  // current product element is the final one
  } status_t;

  // Zero reads as one, anything above MAX_DIM as MAX_DIM
  function automatic dim_t clamp_dim(dim_t v);
    dim_t res;
    if (v == '0) begin
      res = dim_t'(1);
    end else if (v > dim_t'(MAX_DIM)) begin
      res = dim_t'(MAX_DIM);
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ sv/matrix_multiply.sv @@
// Matrix multiply block, top level: controller and datapath.
// Depends on mm_pkg, mm_ctrl, mm_datapath (which uses mm_ram).
//
// Usage: write rows_a, inner_dim and cols_b (indexes 0..2) on the cfg port
// while idle; values of 0 act as 1, values above 8 act as 8. Any such write
// restarts the load. Then send A (rows_a x inner_dim) followed by B
// (inner_dim x cols_b), row-major, one element per transfer on the
// element channel; the element channel takes one transfer per cycle.
// The transfer of the last B element starts the product walk and the
// element channel stays not ready until the final result is taken.
// Each product element takes inner_dim store reads, which pass through the
// read and multiply stages into the accumulate (the accumulate loads the
// result register directly). The single multiplier takes one A/B pair per
// cycle from the two store read ports while the walk issues reads; the walk
// issues the next element only after the result is taken.
// The final product element carries last_result. A stalled receiver holds
// the result and pauses the walk. Reset sets all dimensions to 8 and
// restarts the load; store contents are not cleared.
`default_nettype none

module matrix_multiply (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [mm_pkg::REG_IDX_W-1:0]         cfg_index,
  input  wire logic [mm_pkg::DIM_W-1:0]             cfg_data,
  input  wire logic                                 element_valid,
  output logic                                      element_ready,
  input  wire logic signed [mm_pkg::ELEM_WIDTH-1:0] element_value,
  output logic                                      result_valid,
  input  wire logic                                 result_ready,
  output logic signed [mm_pkg::PROD_WIDTH-1:0]      product_value,
  output logic [mm_pkg::IDX_W-1:0]                  row_index,
  output logic [mm_pkg::IDX_W-1:0]                  col_index,
  output logic                                      last_result
);

  mm_pkg::cmd_t    cmd;
  mm_pkg::status_t status;

  // Controller
  mm_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .element_valid (element_valid),
    .element_ready (element_ready),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .status        (status),
    .cmd           (cmd)
  );

  // Datapath
  mm_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .element_value (element_value),
    .cmd           (cmd),
    .status        (status),
    .product_value (product_value),
    .row_index     (row_index),
    .col_index     (col_index),
    .last_result   (last_result)
  );

endmodule

`default_nettype wire

@@ sv/mm_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module mm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ sv/mm_ctrl.sv @@
// Controller state machine for the matrix multiply block.
// Depends on mm_pkg (state_t, cmd_t, status_t).
`default_nettype none

module mm_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            element_valid,
  output logic                 element_ready,
  output logic                 result_valid,
  input  wire logic            result_ready,
  input  wire mm_pkg::status_t status,
  output mm_pkg::cmd_t         cmd
);

  mm_pkg::state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mm_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      mm_pkg::ST_LOAD: begin
        if (element_valid && status.load_last) state_next = mm_pkg::ST_ISSUE;
      end
      mm_pkg::ST_ISSUE: begin
        if (status.issue_last) state_next = mm_pkg::ST_DRAIN;
      end
      mm_pkg::ST_DRAIN: begin
        if (status.mac_done) state_next = mm_pkg::ST_EMIT;
      end
      mm_pkg::ST_EMIT: begin
        if (result_ready) begin
          state_next = status.elem_last ? mm_pkg::ST_LOAD : mm_pkg::ST_ISSUE;
        end
      end
      default: state_next = mm_pkg::ST_LOAD;
    endcase
  end

  // Outputs
  always_comb begin
    element_ready  = 1'b0;
    result_valid   = 1'b0;
    cmd            = '0;
    case (state)
      mm_pkg::ST_LOAD: begin
        element_ready = 1'b1;
        cmd.load      = element_valid;
        cmd.start     = element_valid && status.load_last;
      end
      mm_pkg::ST_ISSUE: begin
        cmd.issue = 1'b1;
      end
      mm_pkg::ST_DRAIN: begin
      end
      mm_pkg::ST_EMIT: begin
        result_valid   = 1'b1;
        cmd.next_elem  = result_ready && !status.elem_last;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

@@ sv/mm_datapath.sv @@
// Datapath of the matrix multiply block: dimension registers, load counter,
// A and B stores, address walk, multiply-accumulate pipe and result register.
// Depends on mm_pkg and mm_ram.
`default_nettype none

module mm_datapath (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [mm_pkg::REG_IDX_W-1:0]    cfg_index,
  input  wire logic [mm_pkg::DIM_W-1:0]        cfg_data,
  input  wire logic signed [mm_pkg::ELEM_WIDTH-1:0] element_value,
  input  wire mm_pkg::cmd_t                    cmd,
  output mm_pkg::status_t                      status,
  output logic signed [mm_pkg::PROD_WIDTH-1:0] product_value,
  output logic [mm_pkg::IDX_W-1:0]             row_index,
  output logic [mm_pkg::IDX_W-1:0]             col_index,
  output logic                                 last_result
);

  mm_pkg::dim_t  rows_a, inner_dim, cols_b;
  mm_pkg::dim_t  ra, id, cb;
  mm_pkg::cnt_t  load_count;
  mm_pkg::tot_t  a_total, total, count_ext;
  logic          load_is_a;
  mm_pkg::addr_t wr_addr;

  mm_pkg::idx_t  r, c, i;
  mm_pkg::addr_t a_base, b_addr, a_rd_addr;
  mm_pkg::idx_t  c_next;

  mm_pkg::elem_t a_rd, b_rd;
  logic          rd_vld, rd_first, rd_last;
  logic          mul_vld, mul_first, mul_last;
  mm_pkg::mul_t  mul_p;
  mm_pkg::prod_t acc, acc_sum;

  // Dimension registers; any register write restarts the load
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a    <= mm_pkg::DIM_RESET;
      inner_dim <= mm_pkg::DIM_RESET;
      cols_b    <= mm_pkg::DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        mm_pkg::REG_ROWS_A:    rows_a    <= cfg_data;
        mm_pkg::REG_INNER_DIM: inner_dim <= cfg_data;
        mm_pkg::REG_COLS_B:    cols_b    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign ra = mm_pkg::clamp_dim(rows_a);
  assign id = mm_pkg::clamp_dim(inner_dim);
  assign cb = mm_pkg::clamp_dim(cols_b);

  // Load bookkeeping
  assign a_total   = mm_pkg::tot_t'(ra) * mm_pkg::tot_t'(id);
  assign total     = a_total + mm_pkg::tot_t'(id) * mm_pkg::tot_t'(cb);
  assign count_ext = mm_pkg::tot_t'(load_count);
  assign load_is_a = count_ext < a_total;
  assign wr_addr   = load_is_a ? mm_pkg::addr_t'(count_ext)
                               : mm_pkg::addr_t'(count_ext - a_total);

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
    end else if (cfg_we && (cfg_index == mm_pkg::REG_ROWS_A ||
                            cfg_index == mm_pkg::REG_INNER_DIM ||
                            cfg_index == mm_pkg::REG_COLS_B)) begin
      load_count <= '0;
    end else if (cmd.start) begin
      load_count <= '0;
    end else if (cmd.load) begin
      load_count <= load_count + mm_pkg::cnt_t'(1);
    end
  end

  // Element stores
  mm_ram #(.WIDTH(mm_pkg::ELEM_WIDTH), .DEPTH(mm_pkg::DEPTH)) u_a_ram (
    .clk   (clk),
    .we    (cmd.load && load_is_a),
    .waddr (wr_addr),
    .wdata (element_value),
    .raddr (a_rd_addr),
    .rdata (a_rd)
  );

  mm_ram #(.WIDTH(mm_pkg::ELEM_WIDTH), .DEPTH(mm_pkg::DEPTH)) u_b_ram (
    .clk   (clk),
    .we    (cmd.load && !load_is_a),
    .waddr (wr_addr),
    .wdata (element_value),
    .raddr (b_addr),
    .rdata (b_rd)
  );

  // Address walk: A at r*id + i, B at i*cb + c
  assign a_rd_addr = a_base + mm_pkg::addr_t'(i);
  assign c_next    = (mm_pkg::dim_t'(c) == cb - mm_pkg::dim_t'(1)) ? '0
                                                                   : c + mm_pkg::idx_t'(1);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      r      <= '0;
      c      <= '0;
      i      <= '0;
      a_base <= '0;
      b_addr <= '0;
    end else if (cmd.next_elem) begin
      c      <= c_next;
      i      <= '0;
      b_addr <= mm_pkg::addr_t'(c_next);
      if (c_next == '0) begin
        r      <= r + mm_pkg::idx_t'(1);
        a_base <= a_base + mm_pkg::addr_t'(id);
      end
    end else if (cmd.issue) begin
      i      <= i + mm_pkg::idx_t'(1);
      b_addr <= b_addr + mm_pkg::addr_t'(cb);
    end
  end

  // Pipe flags: read, multiply, accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld  <= 1'b0;
      mul_vld <= 1'b0;
    end else begin
      rd_vld  <= cmd.issue;
      mul_vld <= rd_vld;
    end
  end

  always_ff @(posedge clk) begin
    rd_first  <= (i == '0);
    rd_last   <= status.issue_last;
    mul_first <= rd_first;
    mul_last  <= rd_last;
    mul_p     <= mm_pkg::mul_t'(a_rd) * mm_pkg::mul_t'(b_rd);
  end

  // Accumulate; the final term loads the result register
  assign acc_sum = (mul_first ? '0 : acc) + mm_pkg::prod_t'(mul_p);

  always_ff @(posedge clk) begin
    if (mul_vld) begin
      acc <= acc_sum;
    end
    if (mul_vld && mul_last) begin
      product_value <= acc_sum;
      row_index     <= r;
      col_index     <= c;
      last_result   <= status.elem_last;
    end
  end

  // Status
  assign status.load_last  = (count_ext + mm_pkg::tot_t'(1)) == total;
  assign status.issue_last = mm_pkg::dim_t'(i) == id - mm_pkg::dim_t'(1);
  assign status.mac_done   = mul_vld && mul_last;
  assign status.elem_last  = (mm_pkg::dim_t'(r) == ra - mm_pkg::dim_t'(1)) &&
                             (mm_pkg::dim_t'(c) == cb - mm_pkg::dim_t'(1));

endmodule

`default_nettype wire
